@@ rtl/core/bsta_pkg.sv @@
// ----------------------------------------------------------------------------
// bsta_pkg
// Shared types and constants for the bad-sector table with alternate map.
// ----------------------------------------------------------------------------
`default_nettype none

package bsta_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;

    localparam int TRACK_W  = 10;
    localparam int HEAD_W   = 3;
    localparam int SECTOR_W = 6;
    localparam int SEL_W    = 7;
    localparam int SPT_W    = 7;
    localparam int HC_W     = 4;

    // register map, word index = paddr[3:2]
    localparam logic [1:0] REG_IGNORE_SOFT = 2'd0;
    localparam logic [1:0] REG_SPT         = 2'd1;
    localparam logic [1:0] REG_HEAD_COUNT  = 2'd2;

    localparam logic [SPT_W-1:0] SPT_RST = 7'd8;
    localparam logic [HC_W-1:0]  HC_RST  = 4'd4;

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [HEAD_W-1:0]   head;
        logic [SECTOR_W-1:0] sector;
        logic                severity;
    } bsta_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/bsta_cell.sv @@
// ----------------------------------------------------------------------------
// bsta_cell
// One table entry of the circulating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bsta_cell (
    input  wire logic                 aclk,
    input  wire logic                 shift_en,
    input  wire bsta_pkg::bsta_entry_t entry_in,
    output bsta_pkg::bsta_entry_t      entry_out
);

    bsta_pkg::bsta_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

`default_nettype wire

@@ rtl/core/bad_sector_table_alternates.sv @@
// ----------------------------------------------------------------------------
// bad_sector_table_alternates
// Bad-sector table held in a ring of cells, with record, map read and clear.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  s_        in    tvalid/tready    tuser: action; tdata: record/read fields
//  m_        out   tvalid/tready    tdata: one result beat per input beat
//  apb       in    psel/penable     three config registers at 0x0, 0x4, 0x8
//
//  record and read-map beats pass through ST_SCAN, where the ring makes one
//  full turn past the head cell, then ST_DONE builds the result.
//  clear, no-op and ignored soft records go from ST_IDLE straight to ST_DONE.
//  reset clears the entry count and registers; ring contents need no reset.
//  the result sits in an output register; a stalled m_ side holds the block
//  in its final cycle until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_sector_table_alternates #(
    parameter int TABLE_ENTRIES = bsta_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // track, head, sector, severity, entry_select
    input  wire logic [1:0]  s_tuser,  // action
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // entry_index, was_new, stored_severity,
                                       // table_full, entry_valid, map_bad_track,
                                       // map_bad_logical, map_alt_logical,
                                       // entry_count
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PS_W   = IDX_W + bsta_pkg::SEL_W;
    localparam int CS_W   = CNT_W + bsta_pkg::SEL_W;
    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] entry_count;
        logic [8:0] map_alt_logical;
        logic [9:0] map_bad_logical;
        logic [9:0] map_bad_track;
        logic       entry_valid;
        logic       table_full;
        logic       stored_severity;
        logic       was_new;
        logic [6:0] entry_index;
    } result_t;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic                         ignore_soft_reg;
    logic [bsta_pkg::SPT_W-1:0]   spt_reg;
    logic [bsta_pkg::HC_W-1:0]    hc_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_soft_reg <= 1'b0;
            spt_reg         <= bsta_pkg::SPT_RST;
            hc_reg          <= bsta_pkg::HC_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bsta_pkg::REG_IGNORE_SOFT: ignore_soft_reg <= pwdata[0];
                bsta_pkg::REG_SPT:         spt_reg <= pwdata[bsta_pkg::SPT_W-1:0];
                bsta_pkg::REG_HEAD_COUNT:  hc_reg <= pwdata[bsta_pkg::HC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bsta_pkg::REG_IGNORE_SOFT: prdata = 32'(ignore_soft_reg);
            bsta_pkg::REG_SPT:         prdata = 32'(spt_reg);
            bsta_pkg::REG_HEAD_COUNT:  prdata = 32'(hc_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // alternate capacity, recomputed every cycle from the stable registers
    logic [10:0]        cap_prod;
    logic signed [12:0] cap_reg;

    assign cap_prod = 11'(spt_reg) * 11'(hc_reg);

    always_ff @(posedge aclk) begin
        cap_reg <= $signed(13'(cap_prod) - 13'({spt_reg, 1'b0}) - 13'd1);
    end

    // ------------------------------------------------------------------------
    // ring of cells
    // ------------------------------------------------------------------------
    bsta_pkg::bsta_entry_t cell_q [TABLE_ENTRIES];
    bsta_pkg::bsta_entry_t wb_entry;
    logic                  shift_en;

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            bsta_pkg::bsta_entry_t cell_d;
            if (k == TABLE_ENTRIES - 1) begin : g_tail
                assign cell_d = wb_entry;
            end else begin : g_mid
                assign cell_d = cell_q[k+1];
            end
            bsta_cell u_cell (
                .aclk      (aclk),
                .shift_en  (shift_en),
                .entry_in  (cell_d),
                .entry_out (cell_q[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    state_t                          state_reg;
    logic [IDX_W-1:0]                pos_reg;
    logic [CNT_W-1:0]                count_reg;
    bsta_pkg::action_t               act_reg;
    logic                            skip_reg;
    bsta_pkg::bsta_entry_t           key_reg;
    logic [bsta_pkg::SEL_W-1:0]      sel_reg;
    logic                            found_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            fsev_reg;
    logic                            hit_reg;
    bsta_pkg::bsta_entry_t           rd_entry_reg;
    result_t                         res_reg;
    logic                            m_tvalid_reg;

    bsta_pkg::bsta_entry_t head;
    logic                  in_use;
    logic                  is_match;
    logic                  is_append;
    logic                  is_sel;
    logic                  s_fire;
    logic                  load_res;
    logic                  in_soft_drop;
    result_t               res_next;
    logic [CNT_W-1:0]      count_next;

    assign head     = cell_q[0];
    assign shift_en = (state_reg == ST_SCAN);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign load_res = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign in_soft_drop = (s_tuser == bsta_pkg::ACT_RECORD) && !s_tdata[19]
                          && ignore_soft_reg;

    assign in_use    = CNT_W'(pos_reg) < count_reg;
    assign is_match  = (act_reg == bsta_pkg::ACT_RECORD) && in_use && !found_reg
                       && head.track == key_reg.track && head.head == key_reg.head
                       && head.sector == key_reg.sector;
    assign is_append = (act_reg == bsta_pkg::ACT_RECORD) && !found_reg
                       && (CNT_W'(pos_reg) == count_reg);
    assign is_sel    = PS_W'(pos_reg) == PS_W'(sel_reg);

    always_comb begin
        wb_entry = head;
        if (is_match) begin
            wb_entry.severity = head.severity | key_reg.severity;
        end else if (is_append) begin
            wb_entry = key_reg;
        end
    end

    // result build for the final cycle
    always_comb begin
        logic [10:0] blog;
        logic        cap_pos;
        logic        rd_valid;

        blog     = 11'(rd_entry_reg.head) * 11'(spt_reg) + 11'(rd_entry_reg.sector)
                   + 11'd1;
        cap_pos  = !cap_reg[12] && (cap_reg != 13'sd0);
        rd_valid = hit_reg && cap_pos && (13'(sel_reg) < $unsigned(cap_reg))
                   && (CS_W'(sel_reg) < CS_W'(count_reg));

        res_next   = '0;
        count_next = count_reg;
        case (act_reg)
            bsta_pkg::ACT_RECORD: begin
                if (skip_reg) begin
                    // soft record dropped, count only
                end else if (found_reg) begin
                    res_next.entry_index     = 7'(idx_reg);
                    res_next.stored_severity = fsev_reg;
                    res_next.entry_valid     = 1'b1;
                end else if (count_reg == CNT_FULL) begin
                    res_next.table_full = 1'b1;
                end else begin
                    res_next.entry_index     = 7'(count_reg);
                    res_next.was_new         = 1'b1;
                    res_next.stored_severity = key_reg.severity;
                    res_next.entry_valid     = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                end
            end
            bsta_pkg::ACT_READ: begin
                res_next.entry_index = sel_reg;
                if (rd_valid) begin
                    res_next.stored_severity = rd_entry_reg.severity;
                    res_next.entry_valid     = 1'b1;
                    res_next.map_bad_track   = rd_entry_reg.track;
                    res_next.map_bad_logical = blog[9:0];
                    res_next.map_alt_logical = 9'({spt_reg, 1'b0}) + 9'd2 + 9'(sel_reg);
                end
            end
            bsta_pkg::ACT_CLEAR: begin
                count_next = '0;
            end
            default: ;
        endcase
        res_next.entry_count = 8'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (load_res) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        act_reg          <= bsta_pkg::action_t'(s_tuser);
                        skip_reg         <= in_soft_drop;
                        key_reg.track    <= s_tdata[9:0];
                        key_reg.head     <= s_tdata[12:10];
                        key_reg.sector   <= s_tdata[18:13];
                        key_reg.severity <= s_tdata[19];
                        sel_reg          <= s_tdata[26:20];
                        found_reg        <= 1'b0;
                        hit_reg          <= 1'b0;
                        pos_reg          <= '0;
                        if ((s_tuser == bsta_pkg::ACT_READ) ||
                            (s_tuser == bsta_pkg::ACT_RECORD && !in_soft_drop)) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (is_match) begin
                        found_reg <= 1'b1;
                        idx_reg   <= pos_reg;
                        fsev_reg  <= head.severity | key_reg.severity;
                    end
                    if (act_reg == bsta_pkg::ACT_READ && is_sel) begin
                        hit_reg      <= 1'b1;
                        rd_entry_reg <= head;
                    end
                    if (pos_reg == POS_LAST) begin
                        pos_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        pos_reg <= pos_reg + IDX_W'(1);
                    end
                end
                ST_DONE: begin
                    if (load_res) begin
                        res_reg   <= res_next;
                        count_reg <= count_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_ring_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_SCAN |-> pos_reg == '0)
        else $error("ring position not aligned outside a scan");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + CNT_W'(1) || count_reg == '0)
        else $error("entry count moved by more than one");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above table size");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_reg.was_new && res_reg.table_full)
                     && !(res_reg.table_full && res_reg.entry_valid))
        else $error("conflicting result flags");

endmodule

`default_nettype wire

@@ dv/tb_bad_sector_table_alternates.sv @@
// ----------------------------------------------------------------------------
// tb_bad_sector_table_alternates
// Self-checking bench for the bad-sector table: a mirror of the table and the
// config registers predicts every result beat, including soft-record drops,
// severity upgrades, full-table drops and alternate-map reads, under several
// sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_bad_sector_table_alternates;
    timeunit 1ns;
    timeprecision 1ps;

    import bsta_pkg::*;

    localparam int DEPTH       = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [7:0] entry_count;
        logic [8:0] map_alt_logical;
        logic [9:0] map_bad_logical;
        logic [9:0] map_bad_track;
        logic       entry_valid;
        logic       table_full;
        logic       stored_severity;
        logic       was_new;
        logic [6:0] entry_index;
    } result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // track, head, sector, severity, entry_select
    logic [1:0]  s_tuser  = '0;  // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // entry_index, was_new, stored_severity, table_full,
                                 // entry_valid, map_bad_track, map_bad_logical,
                                 // map_alt_logical, entry_count

    bad_sector_table_alternates #(.TABLE_ENTRIES(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mirror of the table and registers
    bsta_entry_t      mirror_table [DEPTH];
    int               mirror_count = 0;
    logic             cfg_ignore_soft = 1'b0;
    logic [SPT_W-1:0] cfg_spt = SPT_RST;
    logic [HC_W-1:0]  cfg_heads = HC_RST;

    result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;
    int err_count      = 0;
    int beat_count     = 0;
    int cycle_count    = 0;

    int n_new = 0, n_match = 0, n_full = 0, n_ignored = 0;
    int n_map_hit = 0, n_map_miss = 0, n_clear = 0, n_nop = 0;

    function automatic string fmt_result(result_t r);
        return $sformatf("idx=%0d new=%0b sev=%0b full=%0b valid=%0b trk=%0d log=%0d alt=%0d cnt=%0d",
                         r.entry_index, r.was_new, r.stored_severity, r.table_full,
                         r.entry_valid, r.map_bad_track, r.map_bad_logical,
                         r.map_alt_logical, r.entry_count);
    endfunction

    // applies one beat to the mirror and returns the result it must produce
    function automatic result_t predict_table_result(action_t act, bsta_entry_t rec,
                                                     logic [SEL_W-1:0] sel);
        result_t r;
        int      cap;
        int      limit;
        int      tmp;
        int      i;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        case (act)
            ACT_RECORD: begin
                if (!rec.severity && cfg_ignore_soft) begin
                    n_ignored++;
                end else begin
                    for (i = 0; i < mirror_count; i++) begin
                        if (!hit && mirror_table[i].track == rec.track &&
                            mirror_table[i].head == rec.head &&
                            mirror_table[i].sector == rec.sector) begin
                            hit = 1'b1;
                            mirror_table[i].severity = mirror_table[i].severity | rec.severity;
                            r.entry_index     = i[6:0];
                            r.stored_severity = mirror_table[i].severity;
                            r.entry_valid     = 1'b1;
                        end
                    end
                    if (hit) begin
                        n_match++;
                    end else if (mirror_count >= DEPTH) begin
                        r.table_full = 1'b1;
                        n_full++;
                    end else begin
                        mirror_table[mirror_count] = rec;
                        r.entry_index     = mirror_count[6:0];
                        r.was_new         = 1'b1;
                        r.stored_severity = rec.severity;
                        r.entry_valid     = 1'b1;
                        mirror_count++;
                        n_new++;
                    end
                end
            end
            ACT_READ: begin
                cap = int'(cfg_spt) * int'(cfg_heads) - 2 * int'(cfg_spt) - 1;
                if (cap <= 0)
                    limit = 0;
                else
                    limit = (cap < mirror_count) ? cap : mirror_count;
                r.entry_index = sel;
                if (int'(sel) < limit) begin
                    r.stored_severity = mirror_table[sel].severity;
                    r.entry_valid     = 1'b1;
                    r.map_bad_track   = mirror_table[sel].track;
                    tmp = int'(mirror_table[sel].head) * int'(cfg_spt)
                        + int'(mirror_table[sel].sector) + 1;
                    r.map_bad_logical = tmp[9:0];
                    tmp = 2 * int'(cfg_spt) + 2 + int'(sel);
                    r.map_alt_logical = tmp[8:0];
                    n_map_hit++;
                end else begin
                    n_map_miss++;
                end
            end
            ACT_CLEAR: begin
                mirror_count = 0;
                n_clear++;
            end
            default: n_nop++;
        endcase
        r.entry_count = mirror_count[7:0];
        return r;
    endfunction

    // sends one beat; s_tvalid stays high afterwards so beats can go back to back
    task automatic push_beat(input action_t act, input int trk, input int hd, input int sec,
                             input int sev, input int sel);
        bsta_entry_t rec;
        int          gap;
        rec.track    = trk[TRACK_W-1:0];
        rec.head     = hd[HEAD_W-1:0];
        rec.sector   = sec[SECTOR_W-1:0];
        rec.severity = sev[0];
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(3) == 0) ? $urandom_range(160, 1) : $urandom_range(4, 1);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, sel[SEL_W-1:0], rec.severity, rec.sector, rec.head, rec.track};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_table_result(act, rec, sel[SEL_W-1:0]));
        beat_count++;
    endtask

    // holds the sender off until every result is back and the block is idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // leaves psel high so that writes can follow each other
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_IGNORE_SOFT: cfg_ignore_soft = value[0];
            REG_SPT:         cfg_spt = value[SPT_W-1:0];
            REG_HEAD_COUNT:  cfg_heads = value[HC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int ign, input int spt, input int heads);
        wait_drained();
        write_reg(REG_IGNORE_SOFT, ign);
        write_reg(REG_SPT, spt);
        write_reg(REG_HEAD_COUNT, heads);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        push_beat(ACT_NOP, 1023, 7, 63, 1, 127);
        push_beat(ACT_CLEAR, 1023, 7, 63, 1, 127);
    endtask

    task automatic test_record_and_map();
        push_beat(ACT_RECORD, 0, 0, 0, 0, 0);
        push_beat(ACT_RECORD, 1023, 7, 63, 1, 127);
        // soft entry raised to hard, hard entry stays hard
        push_beat(ACT_RECORD, 0, 0, 0, 1, 0);
        push_beat(ACT_RECORD, 1023, 7, 63, 0, 0);
        push_beat(ACT_RECORD, 512, 3, 21, 0, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 1);
        push_beat(ACT_READ, 0, 0, 0, 0, 2);
        push_beat(ACT_READ, 0, 0, 0, 0, 3);
        push_beat(ACT_READ, 1023, 7, 63, 1, 127);
        // soft records dropped, even when they match an entry
        set_config(1, 8, 4);
        push_beat(ACT_RECORD, 5, 1, 1, 0, 0);
        push_beat(ACT_RECORD, 5, 1, 1, 1, 0);
        push_beat(ACT_RECORD, 0, 0, 0, 0, 0);
        // zero capacity, then the widest register values
        set_config(0, 1, 3);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        set_config(0, 64, 8);
        push_beat(ACT_READ, 0, 0, 0, 0, 1);
        set_config(0, 127, 15);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 1);
        set_config(1, 0, 15);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        set_config(0, 127, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 1);
        push_beat(ACT_CLEAR, 0, 0, 0, 0, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
    endtask

    task automatic test_table_full();
        int i;
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        set_config(0, 64, 8);
        push_beat(ACT_CLEAR, 0, 0, 0, 0, 0);
        for (i = 0; i < DEPTH; i++)
            push_beat(ACT_RECORD, i, $urandom_range(7), $urandom_range(63), $urandom_range(1), 0);
        push_beat(ACT_RECORD, 1000, 2, 9, 1, 0);
        push_beat(ACT_RECORD, 1001, 2, 9, 0, 0);
        push_beat(ACT_RECORD, 50, mirror_table[50].head, mirror_table[50].sector, 1, 0);
        push_beat(ACT_READ, 0, 0, 0, 0, 127);
        push_beat(ACT_READ, 0, 0, 0, 0, 0);
        // capacity below the entry count
        set_config(0, 8, 4);
        push_beat(ACT_READ, 0, 0, 0, 0, 14);
        push_beat(ACT_READ, 0, 0, 0, 0, 15);
        push_beat(ACT_CLEAR, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 62, 0, 35};
        int recv_pct [4] = '{0, 0, 62, 35};
        int phase;
        int chunk;
        int n;
        int pick;
        int j;
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            for (chunk = 0; chunk < 4; chunk++) begin
                case ($urandom_range(7))
                    0: set_config($urandom_range(1), 64, 8);
                    1: set_config($urandom_range(1), 1, 8);
                    2: set_config($urandom_range(1), 127, 15);
                    3: set_config($urandom_range(1), $urandom_range(127), $urandom_range(15));
                    default: set_config($urandom_range(1), $urandom_range(64, 1),
                                        $urandom_range(8, 3));
                endcase
                for (n = 0; n < 100; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        if (mirror_count > 0 && $urandom_range(1) == 0) begin
                            j = $urandom_range(mirror_count - 1);
                            push_beat(ACT_RECORD, mirror_table[j].track, mirror_table[j].head,
                                      mirror_table[j].sector, $urandom_range(1),
                                      $urandom_range(127));
                        end else begin
                            push_beat(ACT_RECORD,
                                      $urandom_range(1) ? $urandom_range(1023) : $urandom_range(15),
                                      $urandom_range(7), $urandom_range(63), $urandom_range(1),
                                      $urandom_range(127));
                        end
                    end else if (pick < 90) begin
                        if (mirror_count > 0 && $urandom_range(3) != 0)
                            j = $urandom_range(mirror_count - 1);
                        else
                            j = $urandom_range(127);
                        push_beat(ACT_READ, $urandom_range(1023), $urandom_range(7),
                                  $urandom_range(63), $urandom_range(1), j);
                    end else if (pick < 93) begin
                        push_beat(ACT_CLEAR, $urandom_range(1023), $urandom_range(7),
                                  $urandom_range(63), $urandom_range(1), $urandom_range(127));
                    end else begin
                        push_beat(ACT_NOP, $urandom_range(1023), $urandom_range(7),
                                  $urandom_range(63), $urandom_range(1), $urandom_range(127));
                    end
                end
            end
        end
    endtask

    // result checking and receiver backpressure
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected result beat: %s", fmt_result(got));
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.entry_index !== want.entry_index || got.was_new !== want.was_new ||
                    got.stored_severity !== want.stored_severity ||
                    got.table_full !== want.table_full ||
                    got.entry_valid !== want.entry_valid ||
                    got.map_bad_track !== want.map_bad_track ||
                    got.map_bad_logical !== want.map_bad_logical ||
                    got.map_alt_logical !== want.map_alt_logical ||
                    got.entry_count !== want.entry_count) begin
                    if (err_count < 10)
                        $display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
                                 cycle_count, fmt_result(want), fmt_result(got));
                    err_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) begin
            m_tready <= 1'b0;
            if ($urandom_range(7) == 0)
                stall_left = $urandom_range(150, 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_record_and_map();
        test_table_full();
        test_random_traffic();
        wait_drained();
        repeat (2 * DEPTH) @(posedge aclk);
        $display("%0d beats: %0d new, %0d matched, %0d full drops, %0d soft drops",
                 beat_count, n_new, n_match, n_full, n_ignored);
        $display("map reads %0d valid / %0d invalid, %0d clears, %0d no-ops, %0d mismatches",
                 n_map_hit, n_map_miss, n_clear, n_nop, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bsta_pkg.sv
rtl/core/bsta_cell.sv
rtl/core/bad_sector_table_alternates.sv
dv/tb_bad_sector_table_alternates.sv
